>>> sv/ecpm_pkg.sv
// ----------------------------------------------------------------------------
// ecpm_pkg
// Shared types and constants of the energy counter power monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ecpm_pkg;

	localparam int HISTORY_DEPTH_DEF = 10;
	localparam int COUNTER_BITS_DEF  = 32;

	localparam int EXP_W    = 5;
	localparam int TIME_W   = 63;
	localparam int ENERGY_W = 63;
	localparam int POWER_W  = 32;
	localparam int FACTOR_W = 30;
	localparam int QUOT_W   = 31;
	localparam int NUM_W    = 73;
	localparam int REM_W    = 63;
	localparam int CNT_W    = 5;

	localparam int MUL_STEPS = FACTOR_W;
	localparam int DIV_STEPS = QUOT_W;

	localparam logic [EXP_W-1:0]    EXP_RESET = 5'd14;
	localparam logic [FACTOR_W-1:0] NJ_PER_J  = 30'd1000000000;
	localparam logic [ENERGY_W-1:0] E_MAX     = {ENERGY_W{1'b1}};
	localparam logic [QUOT_W-1:0]   P_MAX     = {QUOT_W{1'b1}};

	typedef struct packed {
		logic capture;
		logic prep;
		logic mul_step;
		logic scale;
		logic num;
		logic div_init;
		logic div_step;
		logic load;
	} ecpm_cmd_t;

	typedef struct packed {
		logic failed;
	} ecpm_sts_t;

endpackage

`default_nettype wire

>>> sv/ecpm_if.sv
// ----------------------------------------------------------------------------
// ecpm_if
// Handshake channels of the power monitor: sample in, result out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecpm_sample_if;
	logic               valid;
	logic               ready;
	logic               domain;
	logic signed [63:0] energy_reading;
	logic        [62:0] sample_time_ns;

	modport source (output valid, output domain, output energy_reading,
		output sample_time_ns, input ready);
	modport sink (input valid, input domain, input energy_reading,
		input sample_time_ns, output ready);
endinterface

interface ecpm_result_if;
	logic               valid;
	logic               ready;
	logic               result_domain;
	logic               read_failed;
	logic        [62:0] energy_nj;
	logic signed [31:0] power_mw;

	modport source (output valid, output result_domain, output read_failed,
		output energy_nj, output power_mw, input ready);
	modport sink (input valid, input result_domain, input read_failed,
		input energy_nj, input power_mw, output ready);
endinterface

interface ecpm_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] energy_unit_exp;

	modport source (output valid, output energy_unit_exp, input ready);
	modport sink (input valid, input energy_unit_exp, output ready);
endinterface

`default_nettype wire

>>> sv/ecpm_ctrl.sv
// ----------------------------------------------------------------------------
// ecpm_ctrl
// Sequencer: capture, delta, shift-add scaling, restoring divide, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpm_ctrl
	import ecpm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sample_valid,
	output      logic      sample_ready,
	output      logic      res_valid,
	input  wire logic      res_ready,
	input  wire ecpm_sts_t sts,
	output      ecpm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_SCALE  = 3'd3;
	localparam logic [2:0] ST_NUM    = 3'd4;
	localparam logic [2:0] ST_DINIT  = 3'd5;
	localparam logic [2:0] ST_DIV    = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             res_valid_q;
	logic             can_load;

	assign sample_ready = (state_q == ST_IDLE);
	assign res_valid    = res_valid_q;
	assign can_load     = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = sts.failed ? ST_FINISH : ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_NUM;
			end
			ST_NUM: begin
				cmd.num = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (can_load) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/ecpm_datapath.sv
// ----------------------------------------------------------------------------
// ecpm_datapath
// Per-domain state, energy scaling, power divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpm_datapath
	import ecpm_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ecpm_cmd_t                  cmd,
	output      ecpm_sts_t                  sts,
	input  wire logic                       cfg_we,
	input  wire logic        [EXP_W-1:0]    cfg_exp,
	input  wire logic                       sample_domain,
	input  wire logic signed [63:0]         sample_energy,
	input  wire logic        [TIME_W-1:0]   sample_time,
	output      logic                       res_domain,
	output      logic                       res_failed,
	output      logic        [ENERGY_W-1:0] res_energy,
	output      logic signed [POWER_W-1:0]  res_power
);

	localparam int PROD_W = COUNTER_BITS + FACTOR_W;
	localparam int ACC_W  = (PROD_W > ENERGY_W) ? PROD_W : ENERGY_W + 1;
	localparam int NHI_W  = NUM_W - QUOT_W;

	logic [EXP_W-1:0]        exp_q;
	logic [COUNTER_BITS-1:0] last_energy_q [2];
	logic [TIME_W-1:0]       last_time_q [2];
	logic [POWER_W-1:0]      hist_q [2][HISTORY_DEPTH];

	logic                    dom_q, failed_q;
	logic [COUNTER_BITS-1:0] cur_q, diff_q;
	logic [TIME_W-1:0]       t_q, elapsed_q;
	logic [FACTOR_W-1:0]     factor_q;
	logic [PROD_W-1:0]       acc_q;
	logic [ENERGY_W-1:0]     energy_q;
	logic [NUM_W-1:0]        num_q;
	logic [REM_W-1:0]        rem_q;
	logic [QUOT_W-1:0]       nlow_q, quot_q;
	logic                    sat_q;

	logic [TIME_W-1:0]  lt;
	logic [TIME_W:0]    tsub;
	logic               later;
	logic [ACC_W-1:0]   acc_ext;
	logic [NUM_W-1:0]   num_d;
	logic [REM_W:0]     trial, trial_sub;
	logic [POWER_W-1:0] power_d;

	assign sts.failed = failed_q;

	assign lt    = last_time_q[dom_q];
	assign tsub  = {1'b0, t_q} - {1'b0, lt};
	assign later = !tsub[TIME_W] && (tsub[TIME_W-1:0] != '0);

	assign acc_ext = ACC_W'(acc_q);

	// x1000 = x*1024 - x*16 - x*8
	assign num_d = {energy_q, 10'b0} - {6'b0, energy_q, 4'b0} - {7'b0, energy_q, 3'b0};

	assign trial     = {rem_q, nlow_q[QUOT_W-1]};
	assign trial_sub = trial - {1'b0, elapsed_q};

	always_comb begin
		if (failed_q) begin
			power_d = '1;
		end else if (sat_q) begin
			power_d = {1'b0, P_MAX};
		end else begin
			power_d = {1'b0, quot_q};
		end
	end

	// state with a defined reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= EXP_RESET;
			for (int d = 0; d < 2; d++) begin
				last_energy_q[d] <= '0;
				last_time_q[d]   <= '0;
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					hist_q[d][i] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				exp_q <= cfg_exp;
			end
			if (cmd.prep) begin
				last_time_q[dom_q] <= t_q;
				if (!failed_q) begin
					last_energy_q[dom_q] <= cur_q;
				end
			end
			if (cmd.load) begin
				for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
					hist_q[dom_q][i] <= hist_q[dom_q][i+1];
				end
				hist_q[dom_q][HISTORY_DEPTH-1] <= power_d;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dom_q    <= sample_domain;
			failed_q <= sample_energy[63];
			cur_q    <= sample_energy[COUNTER_BITS-1:0];
			t_q      <= sample_time;
			factor_q <= NJ_PER_J >> exp_q;
			energy_q <= '0;
		end
		if (cmd.prep) begin
			elapsed_q <= (lt != '0 && later) ? tsub[TIME_W-1:0] : TIME_W'(1);
			diff_q    <= cur_q - last_energy_q[dom_q];
			acc_q     <= '0;
		end
		if (cmd.mul_step) begin
			acc_q    <= {acc_q[PROD_W-2:0], 1'b0}
				+ (factor_q[FACTOR_W-1] ? PROD_W'(diff_q) : '0);
			factor_q <= {factor_q[FACTOR_W-2:0], 1'b0};
		end
		if (cmd.scale) begin
			energy_q <= (|acc_ext[ACC_W-1:ENERGY_W]) ? E_MAX : acc_ext[ENERGY_W-1:0];
		end
		if (cmd.num) begin
			num_q <= num_d;
		end
		if (cmd.div_init) begin
			rem_q  <= {{(REM_W - NHI_W){1'b0}}, num_q[NUM_W-1:QUOT_W]};
			nlow_q <= num_q[QUOT_W-1:0];
			sat_q  <= {{(REM_W - NHI_W){1'b0}}, num_q[NUM_W-1:QUOT_W]} >= elapsed_q;
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			nlow_q <= {nlow_q[QUOT_W-2:0], 1'b0};
			if (!trial_sub[REM_W]) begin
				rem_q  <= trial_sub[REM_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[REM_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
		if (cmd.load) begin
			res_domain <= dom_q;
			res_failed <= failed_q;
			res_energy <= energy_q;
			res_power  <= power_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/energy_counter_power_monitor_core.sv
// ----------------------------------------------------------------------------
// energy_counter_power_monitor_core
// Energy counter samples in, scaled energy and average power out.
// ----------------------------------------------------------------------------
// Each sample word carries a domain (core or package), a raw counter reading
// and a nanosecond timestamp. A good reading passes from acceptance to a
// loaded result through these steps: compute the counter and time deltas,
// shift-add scaling by 1e9 >> energy_unit_exp, saturate, multiply by 1000
// and check quotient overflow, restoring division by the elapsed time, and
// load the result register. A failed (negative) reading skips the
// arithmetic and goes from the delta step straight to the load. The input
// is ready again in the cycle after the load, so a new sample is not taken
// before the last one has been loaded. The next sample is taken once the
// result has moved
// into the output register, so a result left waiting there does not hold off
// the following sample; only a second finished result waits for it.
// The per-domain power history is held in flip-flops cleared by reset, so no
// clearing pass is needed. Write energy_unit_exp only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_counter_power_monitor_core
	import ecpm_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ecpm_sample_if.sink   sample,
	ecpm_result_if.source result,
	ecpm_cfg_if.sink      cfg
);

	ecpm_cmd_t cmd;
	ecpm_sts_t sts;

	// config always lands at once: drop nothing, stall nothing
	assign cfg.ready = 1'b1;

	// sequence the word through the datapath
	ecpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// hold per-domain state, advance the arithmetic, present the result word
	ecpm_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.COUNTER_BITS  (COUNTER_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg.valid),
		.cfg_exp       (cfg.energy_unit_exp),
		.sample_domain (sample.domain),
		.sample_energy (sample.energy_reading),
		.sample_time   (sample.sample_time_ns),
		.res_domain    (result.result_domain),
		.res_failed    (result.read_failed),
		.res_energy    (result.energy_nj),
		.res_power     (result.power_mw)
	);

	// a taken word starts the sequence: no second word the cycle after
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample taken while a word is in flight");

	// a failed read reports -1 mW and no energy
	a_failed_power: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.read_failed) |-> (result.power_mw == -32'sd1))
		else $error("failed read without -1 power");

	a_failed_energy: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.read_failed) |-> (result.energy_nj == '0))
		else $error("failed read with nonzero energy");

	// a good read saturates and never goes negative
	a_good_power: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.read_failed) |-> !result.power_mw[31])
		else $error("good read with negative power");

endmodule

`default_nettype wire

>>> dv/ecpm_power_checker.sv
// ----------------------------------------------------------------------------
// ecpm_power_checker
// Watches the sample, result and config channels of the power monitor and
// predicts each result word from the accepted samples. It compares every
// result field by field and counts the mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module ecpm_power_checker
	import ecpm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	ecpm_sample_if    sample,
	ecpm_result_if    result,
	ecpm_cfg_if       cfg,
	output int        mismatches,
	output int        outstanding
);

	typedef struct packed {
		logic                       dom;
		logic                       failed;
		logic [ENERGY_W-1:0]        nj;
		logic signed [POWER_W-1:0]  mw;
	} power_result_t;

	power_result_t       expected_results[$];
	logic [EXP_W-1:0]    unit_exp;
	logic [31:0]         prev_count[2];
	logic [TIME_W-1:0]   prev_stamp[2];

	// Energy delta since the last good reading, scaled, then divided by elapsed ns.
	task automatic predict_sample();
		power_result_t       r;
		logic                d;
		logic [TIME_W-1:0]   stamp;
		logic [TIME_W-1:0]   elapsed;
		logic [31:0]         count;
		logic [31:0]         delta;
		logic [FACTOR_W-1:0] scale;
		logic [127:0]        quot;
		d = sample.domain;
		stamp = sample.sample_time_ns;
		elapsed = TIME_W'(1);
		if (prev_stamp[d] != 0 && stamp > prev_stamp[d])
			elapsed = stamp - prev_stamp[d];
		prev_stamp[d] = stamp;
		r.dom = d;
		r.failed = sample.energy_reading[63];
		if (r.failed) begin
			r.nj = '0;
			r.mw = '1;
		end else begin
			count = sample.energy_reading[31:0];
			delta = count - prev_count[d];
			prev_count[d] = count;
			scale = NJ_PER_J >> unit_exp;
			r.nj = ENERGY_W'(delta) * ENERGY_W'(scale);
			quot = (128'(r.nj) * 128'd1000) / 128'(elapsed);
			r.mw = (quot > 128'(P_MAX)) ? POWER_W'(P_MAX) : quot[31:0];
		end
		expected_results.push_back(r);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	task automatic check_result();
		power_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result word, expected none, actual %0h/%0h/%0h/%0h",
				$time, result.result_domain, result.read_failed, result.energy_nj,
				result.power_mw);
		end else begin
			want = expected_results.pop_front();
			check_field("result_domain", 64'(want.dom), 64'(result.result_domain));
			check_field("read_failed", 64'(want.failed), 64'(result.read_failed));
			check_field("energy_nj", 64'(want.nj), 64'(result.energy_nj));
			check_field("power_mw", 64'(unsigned'(want.mw)),
				64'(unsigned'(result.power_mw)));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_exp = EXP_RESET;
			prev_count[0] = '0;
			prev_count[1] = '0;
			prev_stamp[0] = '0;
			prev_stamp[1] = '0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (result.valid && result.ready)
				check_result();
			if (cfg.valid && cfg.ready)
				unit_exp = cfg.energy_unit_exp;
			if (sample.valid && sample.ready)
				predict_sample();
		end
		outstanding = expected_results.size();
	end

endmodule

`default_nettype wire

>>> dv/energy_counter_power_monitor_core_test.sv
// ----------------------------------------------------------------------------
// energy_counter_power_monitor_core_test
// Drives samples and unit exponent writes into the power monitor core.
// ----------------------------------------------------------------------------
// A short directed run covers first samples, zero and backward time, failed
// reads, counter wrap, extreme readings and timestamps and the extreme unit
// exponents. Random phases follow, each under its own exponent, made mostly
// of plausible counter traces per domain mixed with failed reads and wild
// words. The result side stalls at random and twice holds off for a long
// stretch so that the block backs up. The checker does all predicting.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_counter_power_monitor_core_test
	import ecpm_pkg::*;
();

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int LONG_HOLD    = 1500;
	localparam int PHASE_ITEMS  = 163;
	localparam int NUM_PHASES   = 8;
	localparam int SETTLE       = 100;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   cycle_count = 0;
	int   words_sent = 0;
	int   words_drained = 0;

	ecpm_sample_if sample ();
	ecpm_result_if result ();
	ecpm_cfg_if    cfg ();

	energy_counter_power_monitor_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);

	ecpm_power_checker power_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.result      (result),
		.cfg         (cfg),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	// Per-domain counter trace that the random samples follow.
	logic [31:0]       trace_count[2];
	logic [TIME_W-1:0] trace_stamp[2];

	// Offer one sample word after a random gap; return at the falling edge
	// after it is taken. With no gap, valid stays high and only the payload moves.
	task automatic send_sample(input logic dom, input logic [63:0] reading,
		input logic [TIME_W-1:0] stamp);
		int unsigned gap;
		gap = $urandom_range(0, 7);
		// back-to-back burst window
		if (words_sent >= 400 && words_sent < 500)
			gap = 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.valid          <= 1'b1;
		sample.domain         <= dom;
		sample.energy_reading <= reading;
		sample.sample_time_ns <= stamp;
		do @(posedge clk); while (!(sample.valid && sample.ready));
		words_sent++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected result word has come back.
	task automatic wait_drained();
		sample.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_unit_exp(input logic [EXP_W-1:0] value);
		wait_drained();
		cfg.valid           <= 1'b1;
		cfg.energy_unit_exp <= value;
		do @(posedge clk); while (!(cfg.valid && cfg.ready));
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Pick the next random sample: mostly a well-formed trace step, the rest
	// failed reads, stalled or backward time, and wholly random words.
	task automatic make_sample(output logic dom, output logic [63:0] reading,
		output logic [TIME_W-1:0] stamp);
		int unsigned       mode;
		logic [31:0]       delta;
		logic [TIME_W-1:0] step;
		dom = 1'($urandom);
		mode = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			step = TIME_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
		else
			step = TIME_W'($urandom_range(1, 2_000_000));
		if ($urandom_range(0, 7) == 0)
			delta = $urandom;
		else
			delta = $urandom_range(0, 65535);
		if (mode < 70) begin
			trace_stamp[dom] = trace_stamp[dom] + step;
			trace_count[dom] = trace_count[dom] + delta;
			stamp = trace_stamp[dom];
			reading = {1'b0, 31'($urandom), trace_count[dom]};
		end else if (mode < 80) begin
			trace_stamp[dom] = trace_stamp[dom] + step;
			stamp = trace_stamp[dom];
			reading = {1'b1, 63'({$urandom, $urandom})};
		end else if (mode < 90) begin
			// hold or step back the clock
			trace_stamp[dom] = trace_stamp[dom] - TIME_W'($urandom_range(0, 1000));
			trace_count[dom] = trace_count[dom] + delta;
			stamp = trace_stamp[dom];
			reading = {1'b0, 31'($urandom), trace_count[dom]};
		end else begin
			stamp = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'({$urandom, $urandom});
			reading = {$urandom, $urandom};
			trace_stamp[dom] = stamp;
			if (!reading[63])
				trace_count[dom] = reading[31:0];
		end
	endtask

	// Result side: random stalls, a burst window with none, and two long holds.
	initial begin : result_drain
		int unsigned hold;
		result.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, 7);
			if (words_drained >= 450 && words_drained < 600)
				hold = 0;
			if (words_drained == 60 || words_drained == 800)
				hold = LONG_HOLD;
			if (hold > 0) begin
				result.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!(result.valid && result.ready));
			words_drained++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic              dom;
		logic [63:0]       reading;
		logic [TIME_W-1:0] stamp;
		logic [EXP_W-1:0]  phase_exp[NUM_PHASES];
		sample.valid          = 1'b0;
		sample.domain         = 1'b0;
		sample.energy_reading = '0;
		sample.sample_time_ns = '0;
		cfg.valid             = 1'b0;
		cfg.energy_unit_exp   = '0;
		trace_count[0] = '0;
		trace_count[1] = '0;
		trace_stamp[0] = '0;
		trace_stamp[1] = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, reset exponent first.
		// First sample of core: no previous time, elapsed counts as 1 ns.
		send_sample(1'b0, 64'd1000, '0);
		// Previous time still zero, so again 1 ns.
		send_sample(1'b0, 64'd2000, 63'd1000);
		send_sample(1'b0, 64'd3000, 63'd2_000_000);
		// Same timestamp, then time running backwards.
		send_sample(1'b0, 64'd3500, 63'd2_000_000);
		send_sample(1'b0, 64'd4000, 63'd1_000_000);
		// Failed reads: most negative and minus one; energy must be kept.
		send_sample(1'b0, 64'h8000_0000_0000_0000, 63'd3_000_000);
		send_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 63'd4_000_000);
		// Largest positive reading at the latest possible time.
		send_sample(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
		// Counter wraps past all ones.
		send_sample(1'b0, 64'd5, 63'd1);
		// Tiny energy over a huge interval rounds power down to zero.
		send_sample(1'b0, 64'd6, 63'h7FFF_FFFF_FFFF_FFFF);
		// Package domain, upper reading bits ignored.
		send_sample(1'b1, 64'h7FFF_FFFF_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
		send_sample(1'b1, 64'h0000_0000_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
		send_sample(1'b1, 64'h5555_5555_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA);

		// Full scale: huge energy over one ns saturates power.
		write_unit_exp(5'd0);
		send_sample(1'b0, 64'h0000_0000_8000_0005, 63'd10);
		send_sample(1'b1, 64'h0000_0000_0000_1234, 63'h2AAA_AAAA_AAAB_AAAA);
		// Scale factor of zero.
		write_unit_exp(5'd31);
		send_sample(1'b0, 64'h0000_0000_FFFF_0000, 63'd20);
		send_sample(1'b1, 64'h0000_0000_0001_0000, 63'h2AAA_AAAA_AAAC_AAAA);
		write_unit_exp(5'd30);
		send_sample(1'b0, 64'h0000_0000_0000_0000, 63'd30);
		// Scale factor of one.
		write_unit_exp(5'd29);
		send_sample(1'b0, 64'h0000_0000_1000_0000, 63'd40);

		// Random phases, each under its own exponent.
		phase_exp[0] = 5'd0;
		phase_exp[1] = 5'd31;
		phase_exp[2] = 5'd5;
		phase_exp[3] = 5'd30;
		phase_exp[4] = EXP_RESET;
		phase_exp[5] = 5'd20;
		phase_exp[6] = 5'($urandom_range(0, 31));
		phase_exp[7] = 5'($urandom_range(0, 31));
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_unit_exp(phase_exp[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				make_sample(dom, reading, stamp);
				send_sample(dom, reading, stamp);
			end
		end

		// Drain, let the pipeline settle, then give the verdict.
		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
